// File: src/ccsd_pkg.sv
// shared types, constants and decode functions for the clock colour and segment driver
package ccsd_pkg;

    // field widths
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int COLOUR_W = 8;
    localparam int SEG_W    = 7;

    // packed stream widths, padded to whole bytes
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 56;

    // floor(k*x/300) for k*x < 2**17 as (k*x*HUE_RECIP) >> HUE_SHIFT
    localparam int HUE_RECIP = 223697;
    localparam int HUE_SHIFT = 26;

    // floor(t*255/29) for t <= 29 as (t*RAMP_MULT) >> RAMP_SHIFT
    localparam int RAMP_MULT  = 2305200;
    localparam int RAMP_SHIFT = 18;

    typedef logic [SEG_W-1:0]    seg_t;
    typedef logic [COLOUR_W-1:0] colour_t;

    typedef struct packed {
        colour_t blue;
        colour_t green;
        colour_t red;
    } rgb_t;

    typedef struct packed {
        seg_t minute_units;
        seg_t minute_tens;
        seg_t hour_units;
        seg_t hour_tens;
    } digits_t;

    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW   = 3'd0,
        SECTOR_YELLOW_GREEN = 3'd1,
        SECTOR_GREEN_CYAN   = 3'd2,
        SECTOR_CYAN_BLUE    = 3'd3,
        SECTOR_BLUE_MAGENTA = 3'd4,
        SECTOR_MAGENTA_RED  = 3'd5
    } sector_t;

    // seven-segment pattern of one decimal digit, dark above nine
    function automatic seg_t seg_decode(input logic [3:0] digit);
        seg_t seg;
        case (digit)
            4'd0:    seg = 7'd119;
            4'd1:    seg = 7'd36;
            4'd2:    seg = 7'd93;
            4'd3:    seg = 7'd109;
            4'd4:    seg = 7'd46;
            4'd5:    seg = 7'd107;
            4'd6:    seg = 7'd123;
            4'd7:    seg = 7'd39;
            4'd8:    seg = 7'd127;
            4'd9:    seg = 7'd111;
            default: seg = '0;
        endcase
        return seg;
    endfunction

    // floor(k*x/300) by constant reciprocal, x <= 300
    function automatic colour_t hue_scale(input logic [8:0] x, input logic [7:0] k);
        logic [35:0] prod;
        prod = 36'(x) * (36'(k) * 36'(HUE_RECIP));
        return prod[HUE_SHIFT +: COLOUR_W];
    endfunction

    // floor(t*255/29) by constant reciprocal, t <= 29
    function automatic colour_t ramp_scale(input logic [4:0] t);
        logic [27:0] prod;
        prod = 28'(t) * 28'(RAMP_MULT);
        return prod[RAMP_SHIFT +: COLOUR_W];
    endfunction

endpackage

// File: src/ccsd_colour.sv
// lit segment colour from the time of day, hue wheel or festive ramp
module ccsd_colour (
    input  logic                            wheel_mode,
    input  logic [ccsd_pkg::MINUTE_W-1:0]   minute,
    input  logic [ccsd_pkg::SECOND_W-1:0]   second,
    output ccsd_pkg::rgb_t                  rgb
);

    logic [5:0]          sec_c;
    logic [4:0]          min_mod30;
    logic [10:0]         hue_pos;
    ccsd_pkg::sector_t   sector;
    logic [10:0]         pair_base;
    logic [9:0]          wheel_t;
    logic [8:0]          tri_dist;
    logic [8:0]          x;
    logic [8:0]          r_sum;
    ccsd_pkg::rgb_t      hue_rgb;
    ccsd_pkg::rgb_t      ramp_rgb;
    logic [5:0]          ramp_pos;

    // leap second clamp
    assign sec_c = (second > 6'd59) ? 6'd59 : second;

    // minute mod 30 over the full 6-bit range
    always_comb begin
        if (minute >= 6'd60) begin
            min_mod30 = 5'(minute - 6'd60);
        end else if (minute >= 6'd30) begin
            min_mod30 = 5'(minute - 6'd30);
        end else begin
            min_mod30 = 5'(minute);
        end
    end

    assign hue_pos = 11'(sec_c) + 11'(min_mod30) * 11'd60;

    // sector of the wheel and start of its 600-step pair
    always_comb begin
        if (hue_pos < 11'd300) begin
            sector = ccsd_pkg::SECTOR_RED_YELLOW;
        end else if (hue_pos < 11'd600) begin
            sector = ccsd_pkg::SECTOR_YELLOW_GREEN;
        end else if (hue_pos < 11'd900) begin
            sector = ccsd_pkg::SECTOR_GREEN_CYAN;
        end else if (hue_pos < 11'd1200) begin
            sector = ccsd_pkg::SECTOR_CYAN_BLUE;
        end else if (hue_pos < 11'd1500) begin
            sector = ccsd_pkg::SECTOR_BLUE_MAGENTA;
        end else begin
            sector = ccsd_pkg::SECTOR_MAGENTA_RED;
        end
    end

    always_comb begin
        if (hue_pos >= 11'd1200) begin
            pair_base = 11'd1200;
        end else if (hue_pos >= 11'd600) begin
            pair_base = 11'd600;
        end else begin
            pair_base = 11'd0;
        end
    end

    // triangle position x = 300 - |t - 300|
    assign wheel_t  = 10'(hue_pos - pair_base);
    assign tri_dist = (wheel_t >= 10'd300) ? 9'(wheel_t - 10'd300) : 9'(10'd300 - wheel_t);
    assign x        = 9'd300 - tri_dist;
    assign r_sum    = 9'd64 + 9'(ccsd_pkg::hue_scale(x, 8'd255));

    // hue wheel colour per sector
    always_comb begin
        case (sector)
            ccsd_pkg::SECTOR_RED_YELLOW: begin
                hue_rgb.red   = 8'd255;
                hue_rgb.green = ccsd_pkg::hue_scale(x, 8'd191);
                hue_rgb.blue  = 8'd0;
            end
            ccsd_pkg::SECTOR_YELLOW_GREEN: begin
                hue_rgb.red   = ccsd_pkg::hue_scale(x, 8'd255);
                hue_rgb.green = 8'd191;
                hue_rgb.blue  = 8'd0;
            end
            ccsd_pkg::SECTOR_GREEN_CYAN: begin
                hue_rgb.red   = ccsd_pkg::hue_scale(x, 8'd64);
                hue_rgb.green = 8'd191 + ccsd_pkg::hue_scale(x, 8'd64);
                hue_rgb.blue  = ccsd_pkg::hue_scale(x, 8'd255);
            end
            ccsd_pkg::SECTOR_CYAN_BLUE: begin
                hue_rgb.red   = 8'd64;
                hue_rgb.green = 8'd64 + ccsd_pkg::hue_scale(x, 8'd191);
                hue_rgb.blue  = 8'd255;
            end
            ccsd_pkg::SECTOR_BLUE_MAGENTA: begin
                hue_rgb.red   = r_sum[8] ? 8'd255 : r_sum[7:0];
                hue_rgb.green = 8'd64;
                hue_rgb.blue  = 8'd255;
            end
            default: begin
                hue_rgb.red   = 8'd255;
                hue_rgb.green = ccsd_pkg::hue_scale(x, 8'd64);
                hue_rgb.blue  = ccsd_pkg::hue_scale(x, 8'd255);
            end
        endcase
    end

    // festive red-green ramp, reversed on odd minutes
    assign ramp_pos = minute[0] ? (6'd59 - sec_c) : sec_c;

    always_comb begin
        ramp_rgb.blue = 8'd0;
        if (ramp_pos < 6'd30) begin
            ramp_rgb.red   = 8'd255;
            ramp_rgb.green = ccsd_pkg::ramp_scale(5'(ramp_pos));
        end else begin
            ramp_rgb.red   = ccsd_pkg::ramp_scale(5'(6'd59 - ramp_pos));
            ramp_rgb.green = 8'd255;
        end
    end

    assign rgb = wheel_mode ? hue_rgb : ramp_rgb;

endmodule

// File: src/ccsd_digits.sv
// splits hour and minute into decimal digits and decodes their segments
module ccsd_digits (
    input  logic [ccsd_pkg::HOUR_W-1:0]     hour,
    input  logic [ccsd_pkg::MINUTE_W-1:0]   minute,
    output ccsd_pkg::digits_t               digits
);

    // tens digit of a value below 64
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60) begin
            t = 3'd6;
        end else if (v >= 6'd50) begin
            t = 3'd5;
        end else if (v >= 6'd40) begin
            t = 3'd4;
        end else if (v >= 6'd30) begin
            t = 3'd3;
        end else if (v >= 6'd20) begin
            t = 3'd2;
        end else if (v >= 6'd10) begin
            t = 3'd1;
        end else begin
            t = 3'd0;
        end
        return t;
    endfunction

    logic [2:0] hour_tens;
    logic [2:0] minute_tens;
    logic [3:0] hour_units;
    logic [3:0] minute_units;

    // decimal split
    assign hour_tens    = tens_of(6'(hour));
    assign minute_tens  = tens_of(minute);
    assign hour_units   = 4'(6'(hour) - 6'(hour_tens) * 6'd10);
    assign minute_units = 4'(minute - 6'(minute_tens) * 6'd10);

    // segment decode
    assign digits.hour_tens    = ccsd_pkg::seg_decode(4'(hour_tens));
    assign digits.hour_units   = ccsd_pkg::seg_decode(hour_units);
    assign digits.minute_tens  = ccsd_pkg::seg_decode(4'(minute_tens));
    assign digits.minute_units = ccsd_pkg::seg_decode(minute_units);

endmodule

// File: src/clock_colour_and_segment_driver.sv
// top level: repeat filter, input register, colour and digit logic, result register
// Takes one time-of-day word per cycle while s_tready is high and gives one result,
// through the input register and then the result register, when the second differs from the last
// one seen; a repeated second is swallowed with no result. The path is an input register,
// a single pass of constant-multiply colour logic and digit decode, then the
// result register; the two registers form a pipeline, so a new word is taken while
// a result still waits on m_tready. Digits are decoded again only when the minute
// changes (flagged on m_tuser), otherwise the held patterns are repeated.
// The mode bit on cfg_wr_data selects hue wheel (1) or festive ramp (0); the user must
// write it only when idle, as the block itself does not enforce this.
module clock_colour_and_segment_driver (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    // input words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ccsd_pkg::S_DATA_W-1:0]     s_tdata,  // hour[4:0], minute[10:5], second[16:11]
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ccsd_pkg::M_DATA_W-1:0]     m_tdata,  // red[7:0], green[15:8], blue[23:16],
                                                        // seg_hour_tens[30:24],
                                                        // seg_hour_units[37:31],
                                                        // seg_minute_tens[44:38],
                                                        // seg_minute_units[51:45]
    output logic                              m_tuser   // digits_redrawn
);

    logic                               wheel_mode_reg;
    logic [6:0]                         prev_second_reg;
    logic [6:0]                         prev_minute_reg;

    logic [ccsd_pkg::HOUR_W-1:0]        in_hour;
    logic [ccsd_pkg::MINUTE_W-1:0]      in_minute;
    logic [ccsd_pkg::SECOND_W-1:0]      in_second;
    logic                               accept;
    logic                               new_second;
    logic                               new_minute;

    logic                               s1_valid_reg;
    logic                               s1_valid_next;
    logic [ccsd_pkg::HOUR_W-1:0]        s1_hour_reg;
    logic [ccsd_pkg::MINUTE_W-1:0]      s1_minute_reg;
    logic [ccsd_pkg::SECOND_W-1:0]      s1_second_reg;
    logic                               s1_redraw_reg;
    logic                               advance;

    ccsd_pkg::rgb_t                     rgb;
    ccsd_pkg::digits_t                  decoded;
    ccsd_pkg::digits_t                  held_digits_reg;
    ccsd_pkg::digits_t                  out_digits;

    logic                               m_valid_reg;
    logic                               m_valid_next;
    ccsd_pkg::rgb_t                     m_rgb_reg;
    ccsd_pkg::digits_t                  m_digits_reg;
    logic                               m_redrawn_reg;

    // unpack input word
    assign in_hour   = s_tdata[4:0];
    assign in_minute = s_tdata[10:5];
    assign in_second = s_tdata[16:11];

    // repeat filter against the last second and minute seen
    assign accept     = s_tvalid && s_tready;
    assign new_second = ({1'b0, in_second} != prev_second_reg);
    assign new_minute = ({1'b0, in_minute} != prev_minute_reg);

    // pipeline flow
    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            wheel_mode_reg <= cfg_wr_data;
        end
    end

    // last second and minute seen
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_second_reg <= '1;
            prev_minute_reg <= '1;
        end else if (accept) begin
            prev_second_reg <= {1'b0, in_second};
            if (new_second && new_minute) begin
                prev_minute_reg <= {1'b0, in_minute};
            end
        end
    end

    // input register valid
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept && new_second) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (accept && new_second) begin
            s1_hour_reg   <= in_hour;
            s1_minute_reg <= in_minute;
            s1_second_reg <= in_second;
            s1_redraw_reg <= new_minute;
        end
    end

    ccsd_colour u_colour (
        .wheel_mode (wheel_mode_reg),
        .minute     (s1_minute_reg),
        .second     (s1_second_reg),
        .rgb        (rgb)
    );

    ccsd_digits u_digits (
        .hour   (s1_hour_reg),
        .minute (s1_minute_reg),
        .digits (decoded)
    );

    // fresh or held digit patterns
    assign out_digits = s1_redraw_reg ? decoded : held_digits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_digits_reg <= '0;
        end else if (advance && s1_redraw_reg) begin
            held_digits_reg <= decoded;
        end
    end

    // result register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_rgb_reg     <= rgb;
            m_digits_reg  <= out_digits;
            m_redrawn_reg <= s1_redraw_reg;
        end
    end

    // pack result word
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_redrawn_reg;
    assign m_tdata  = {4'b0000,
                       m_digits_reg.minute_units,
                       m_digits_reg.minute_tens,
                       m_digits_reg.hour_units,
                       m_digits_reg.hour_tens,
                       m_rgb_reg.blue,
                       m_rgb_reg.green,
                       m_rgb_reg.red};

endmodule
